FILE: rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue: operation codes,
// status codes, field widths and the per-cell command group.
// ----------------------------------------------------------------------------
package deq_pkg;

    // payload widths, fixed by the request/response format
    localparam int unsigned WordW       = 32;
    localparam int unsigned EntryCountW = 5;

    // operation codes carried in a request
    typedef enum logic [1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_REAR  = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_REAR   = 2'd3
    } t_mode;

    // status codes returned with every response
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef logic signed [WordW-1:0] t_word;

    // command broadcast to every cell of the chain, at most one bit set
    typedef struct packed {
        logic shift_in;   // push front: every cell takes its left neighbour
        logic shift_out;  // pop front: every cell takes its right neighbour
        logic append;     // push rear: first empty cell loads the word
        logic drop;       // pop rear: last occupied cell empties
    } t_cell_cmd;

endpackage

FILE: rtl/deq_if.sv
// ----------------------------------------------------------------------------
// deq_req_if / deq_rsp_if
// Valid/ready channels for deque requests and responses.
// ----------------------------------------------------------------------------
interface deq_req_if
    import deq_pkg::*;
();
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    t_word       value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface deq_rsp_if
    import deq_pkg::*;
();
    logic                   valid;
    logic                   ready;
    t_word                  popped_value;
    logic [1:0]             status;
    logic [EntryCountW-1:0] entry_count;

    modport source (output valid, output popped_value, output status,
                    output entry_count, input ready);
    modport sink   (input valid, input popped_value, input status,
                    input entry_count, output ready);
endinterface

FILE: rtl/deq_cell.sv
// ----------------------------------------------------------------------------
// deq_cell
// One slot of the deque chain. Holds a word and an occupied flag, and
// trades contents with neighbours on front push/pop; fills or empties at rear.
// ----------------------------------------------------------------------------
module deq_cell
    import deq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  t_word     i_value,
    input  t_word     i_left_word,
    input  logic      i_left_valid,
    input  t_word     i_right_word,
    input  logic      i_right_valid,
    output t_word     o_word,
    output logic      o_valid,
    output logic      o_tail
);

    t_word r_word;
    logic  r_valid;

    // occupied flag: shifts with the data, set on append, cleared on drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.shift_in) begin
            r_valid <= i_left_valid;
        end else if (i_cmd.shift_out) begin
            r_valid <= i_right_valid;
        end else if (i_cmd.append && i_left_valid && !r_valid) begin
            r_valid <= 1'b1;
        end else if (i_cmd.drop && r_valid && !i_right_valid) begin
            r_valid <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_in) begin
            r_word <= i_left_word;
        end else if (i_cmd.shift_out) begin
            r_word <= i_right_word;
        end else if (i_cmd.append && i_left_valid && !r_valid) begin
            r_word <= i_value;
        end
    end

    assign o_word  = r_word;
    assign o_valid = r_valid;
    assign o_tail  = r_valid && !i_right_valid;

endmodule

FILE: rtl/double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded deque of signed words, held in a chain of DEPTH cells with the
// front at cell 0. One request in, one response out.
// ----------------------------------------------------------------------------
// Response: registered in the cycle after its request is taken.
// Throughput: one request per cycle while the response side keeps taking;
//   the single response register is the only stall point.
// Reset: synchronous; clears the occupied flags and the count directly,
//   with no clearing pass. Cell words are not reset.
module double_ended_queue_top
    import deq_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    deq_req_if.sink        i_req,
    deq_rsp_if.source      o_rsp
);

    localparam int unsigned CntW = $clog2(DEPTH + 1);

    t_cell_cmd         w_cmd;
    t_word             w_word  [DEPTH];
    logic [DEPTH-1:0]  w_valid;
    logic [DEPTH-1:0]  w_tail;
    t_word             w_rear_word;
    logic              w_acc;
    logic              w_full;
    logic              w_empty;

    logic [CntW-1:0]        r_count;
    logic [CntW-1:0]        n_count;
    logic                   r_out_valid;
    t_word                  r_popped;
    t_word                  n_popped;
    t_status                r_status;
    t_status                n_status;
    logic [EntryCountW-1:0] r_count_out;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_full      = w_valid[DEPTH-1];
    assign w_empty     = !w_valid[0];

    // cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_word w_lw;
        t_word w_rw;
        logic  w_lv;
        logic  w_rv;
        if (g == 0) begin : g_first
            assign w_lw = i_req.value;
            assign w_lv = 1'b1;
        end else begin : g_mid_l
            assign w_lw = w_word[g-1];
            assign w_lv = w_valid[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_rw = '0;
            assign w_rv = 1'b0;
        end else begin : g_mid_r
            assign w_rw = w_word[g+1];
            assign w_rv = w_valid[g+1];
        end
        deq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_value      (i_req.value),
            .i_left_word  (w_lw),
            .i_left_valid (w_lv),
            .i_right_word (w_rw),
            .i_right_valid(w_rv),
            .o_word       (w_word[g]),
            .o_valid      (w_valid[g]),
            .o_tail       (w_tail[g])
        );
    end

    // rear word: only the tail cell passes its word
    always_comb begin
        w_rear_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_rear_word = w_rear_word | (w_word[i] & {WordW{w_tail[i]}});
        end
    end

    // decode request into a chain command and response fields
    always_comb begin
        w_cmd    = '0;
        n_count  = r_count;
        n_popped = '0;
        n_status = ST_OK;
        unique case (t_mode'(i_req.mode))
            MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                    if (t_mode'(i_req.mode) == MODE_PUSH_FRONT) begin
                        w_cmd.shift_in = w_acc;
                    end else begin
                        w_cmd.append = w_acc;
                    end
                end
            end
            MODE_POP_FRONT: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count         = r_count - 1'b1;
                    n_popped        = w_word[0];
                    w_cmd.shift_out = w_acc;
                end
            end
            MODE_POP_REAR: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count    = r_count - 1'b1;
                    n_popped   = w_rear_word;
                    w_cmd.drop = w_acc;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // count and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_count <= n_count;
            end
            if (w_acc) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_popped    <= n_popped;
            r_status    <= n_status;
            r_count_out <= EntryCountW'(n_count);
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.popped_value = r_popped;
    assign o_rsp.status       = r_status;
    assign o_rsp.entry_count  = r_count_out;

    // count tracks the occupied cells
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == r_count)
        else $error("count differs from occupied cells");

    // at most one cell is the tail of the occupied run
    a_single_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tail))
        else $error("more than one tail cell");

    // a taken request always yields a response next cycle
    a_rsp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_out_valid)
        else $error("response missing after request");

    // full status only when every cell is occupied
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_FULL) |-> r_count == CntW'(DEPTH))
        else $error("full status with free cells");

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for double_ended_queue_top. Requests are driven with
// random gaps and the response side stalls at random, with one long hold-off
// that backs the block up. A scoreboard keeps its own ring of words and
// predicts the popped word, status and entry count of every request.
// ----------------------------------------------------------------------------
module tb;
    import deq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned QDepth     = 16;
    localparam int unsigned HoldCycles = 60;
    localparam int unsigned RandomReqs = 800;

    typedef struct {
        t_word                  popped;
        t_status                status;
        logic [EntryCountW-1:0] count;
    } t_deq_result;

    // ------------------------------------------------------------------------
    // Scoreboard: ring model of the deque plus the queue of expected responses
    // ------------------------------------------------------------------------
    class deque_scoreboard;
        t_word       ring [QDepth];
        int unsigned head;
        int unsigned held;
        t_deq_result expected_rsp [$];
        int unsigned mismatch_count;

        function new();
            head           = 0;
            held           = 0;
            mismatch_count = 0;
        endfunction

        // apply one accepted request to the model and queue its response
        function void note_request(t_mode op, t_word word);
            t_deq_result r;
            r.popped = '0;
            r.status = ST_OK;
            unique case (op)
                MODE_PUSH_FRONT: begin
                    if (held == QDepth) begin
                        r.status = ST_FULL;
                    end else begin
                        head       = (head + QDepth - 1) % QDepth;
                        ring[head] = word;
                        held++;
                    end
                end
                MODE_PUSH_REAR: begin
                    if (held == QDepth) begin
                        r.status = ST_FULL;
                    end else begin
                        ring[(head + held) % QDepth] = word;
                        held++;
                    end
                end
                MODE_POP_FRONT: begin
                    if (held == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.popped = ring[head];
                        head     = (head + 1) % QDepth;
                        held--;
                    end
                end
                default: begin
                    if (held == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.popped = ring[(head + held - 1) % QDepth];
                        held--;
                    end
                end
            endcase
            r.count = EntryCountW'(held);
            expected_rsp.push_back(r);
        endfunction

        // compare one accepted response against the oldest expectation
        function void check_response(t_word popped, logic [1:0] status,
                                     logic [EntryCountW-1:0] count);
            t_deq_result want;
            if (expected_rsp.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected response popped=%0d status=%0d count=%0d",
                             $realtime, popped, status, count);
                return;
            end
            want = expected_rsp.pop_front();
            if (popped !== want.popped || status !== want.status || count !== want.count) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: mismatch popped %0d/%0d status %0d/%0d count %0d/%0d (exp/act)",
                             $realtime, want.popped, popped, want.status, status,
                             want.count, count);
            end
        endfunction

        function int unsigned pending_count();
            return expected_rsp.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   calm;      // no idling on either side while set
    bit   hold_rsp;  // response side holds off while set

    deq_req_if req_if ();
    deq_rsp_if rsp_if ();

    deque_scoreboard sb = new();

    double_ended_queue_top #(
        .DEPTH (QDepth)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // drive one request from a falling edge until it is taken; returns at a falling edge
    task automatic send_req(t_mode op, t_word word);
        while (!calm && !hold_rsp && $urandom_range(99) < 20) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid = 1'b1;
        req_if.mode  = op;
        req_if.value = word;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(op, word);
        @(negedge i_clk);
    endtask

    // response side: random stalls, plus one long hold-off counted here
    initial begin
        int unsigned hold_cnt;
        hold_cnt     = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_rsp) begin
                rsp_if.ready = 1'b0;
                hold_cnt++;
                if (hold_cnt == HoldCycles) begin
                    hold_rsp = 1'b0;
                    hold_cnt = 0;
                end
            end else begin
                rsp_if.ready = i_rst_n && (calm || $urandom_range(99) >= 20);
            end
        end
    end

    // check responses at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_response(rsp_if.popped_value, rsp_if.status, rsp_if.entry_count);
    end

    // stimulus and verdict
    initial begin
        int unsigned bias;
        int unsigned push_pct;
        t_mode       op;
        t_word       word;
        i_rst_n      = 1'b0;
        calm         = 1'b0;
        hold_rsp     = 1'b0;
        bias         = 2;
        req_if.valid = 1'b0;
        req_if.mode  = MODE_PUSH_FRONT;
        req_if.value = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // pops on an empty deque
        send_req(MODE_POP_FRONT, 32'sd5);
        send_req(MODE_POP_REAR, -32'sd5);
        // extremes pushed at both ends, then taken back from both ends
        send_req(MODE_PUSH_FRONT, 32'sh8000_0000);
        send_req(MODE_PUSH_REAR, 32'sh7FFF_FFFF);
        send_req(MODE_PUSH_FRONT, -32'sd1);
        send_req(MODE_PUSH_REAR, 32'sd0);
        send_req(MODE_POP_FRONT, 32'sd0);
        send_req(MODE_POP_REAR, 32'sd0);
        send_req(MODE_POP_REAR, 32'sd0);
        send_req(MODE_POP_FRONT, 32'sd0);   // last entry out
        // fill to the brim from both ends, wrapping the head, then overfill
        for (int i = 0; i < QDepth; i++)
            send_req((i % 2) ? MODE_PUSH_REAR : MODE_PUSH_FRONT,
                     t_word'(32'hA5A5_5A5A ^ (32'h1 << (2 * i))));
        send_req(MODE_PUSH_FRONT, 32'sd1);
        send_req(MODE_PUSH_REAR, 32'sd2);

        // random phases leaning towards filling, draining or neither
        for (int n = 0; n < RandomReqs; n++) begin
            if (n % 40 == 0)
                bias = $urandom_range(2);
            if (n == 150)
                hold_rsp = 1'b1;
            calm = (n >= 400 && n < 550);
            push_pct = (bias == 0) ? 75 : (bias == 1) ? 25 : 50;
            if ($urandom_range(99) < push_pct)
                op = $urandom_range(1) ? MODE_PUSH_REAR : MODE_PUSH_FRONT;
            else
                op = $urandom_range(1) ? MODE_POP_REAR : MODE_POP_FRONT;
            case ($urandom_range(15))
                0:       word = 32'sh8000_0000;
                1:       word = 32'sh7FFF_FFFF;
                2:       word = -32'sd1;
                3:       word = 32'sd0;
                default: word = t_word'($urandom);
            endcase
            send_req(op, word);
        end
        req_if.valid = 1'b0;
        calm         = 1'b0;

        // drain, then allow for the response register
        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (sb.mismatch_count == 0 && sb.pending_count() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog
    initial begin
        #2ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: files.f
rtl/deq_pkg.sv
rtl/deq_if.sv
rtl/deq_cell.sv
rtl/double_ended_queue_top.sv
test/tb.sv
